// ===== rtl/keyboard_scan_code_decoder_macros.svh =====
// Assertion macros for the keyboard scan code decoder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef KEYBOARD_SCAN_CODE_DECODER_MACROS_SVH
`define KEYBOARD_SCAN_CODE_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KSD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyboard scan code decoder: assertion failed");

// Next-cycle implication, disabled during reset.
`define KSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyboard scan code decoder: assertion failed");

`endif

// ===== rtl/ksd_pkg.sv =====
// Shared constants and types for the keyboard scan code decoder.
// No dependencies; used by the interface and all RTL modules.
package ksd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned KEY_COUNT       = 128;
  localparam int unsigned KEY_W           = $clog2(KEY_COUNT);
  localparam int unsigned SLOT_W          = 5;
  localparam int unsigned SKIP_W          = 3;

  localparam logic [7:0] CODE_PAUSE  = 8'hE1;
  localparam logic [7:0] CODE_PANIC  = 8'h46;
  localparam logic [7:0] CODE_EXT    = 8'hE0;
  localparam logic [7:0] CODE_RESEND = 8'hFE;
  localparam logic [7:0] CODE_ACK    = 8'hFA;
  localparam logic [7:0] CODE_NONE   = 8'h00;
  localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [SKIP_W-1:0] PAUSE_SKIP = 3'd5;

  typedef struct packed {
    logic [7:0] scan_byte;
  } ksd_scan_t;

  typedef struct packed {
    logic led_command_mode;
  } ksd_cfg_t;

  typedef struct packed {
    logic              code_valid;
    logic [7:0]        key_code;
    logic [SLOT_W-1:0] queue_slot;
    logic              last_scan_update;
    logic              key_is_down;
    logic              pause_seen;
    logic              panic_seen;
    logic              ack_seen;
    logic              resend_seen;
  } ksd_result_t;

  // One decode step handed from the input register to the decode core.
  typedef struct packed {
    logic       fire;
    logic [7:0] scan_byte;
  } ksd_step_t;

endpackage

// ===== rtl/ksd_stream_if.sv =====
// Valid/ready channel carrying one payload struct per request.
// Payload type comes from ksd_pkg at instantiation.
interface ksd_stream_if #(
  parameter type payload_t = ksd_pkg::ksd_scan_t
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ksd_core.sv =====
// Decode core: scan state registers plus the per-byte decode logic.
// Depends on ksd_pkg.
module ksd_core #(
  parameter int unsigned QUEUE_DEPTH = ksd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  ksd_pkg::ksd_cfg_t   cfg_data_i,
  input  ksd_pkg::ksd_step_t  step_i,
  output ksd_pkg::ksd_result_t result_o
);

  localparam int unsigned TAIL_W = $clog2(QUEUE_DEPTH);

  logic                          mode_q;
  logic [ksd_pkg::KEY_COUNT-1:0] down_map_q, down_map_d;
  logic                          ext_q, ext_d;
  logic [ksd_pkg::SKIP_W-1:0]    skip_q, skip_d;
  logic [TAIL_W-1:0]             tail_q, tail_d;
  logic [TAIL_W+ksd_pkg::SLOT_W-1:0] tail_ext;

  logic                      rel;
  logic [ksd_pkg::KEY_W-1:0] key;
  logic [ksd_pkg::KEY_W-1:0] idx;
  logic                      drop;
  logic [7:0]                code;

  assign tail_ext = {{ksd_pkg::SLOT_W{1'b0}}, tail_q};

  always_comb begin
    result_o   = '0;
    down_map_d = down_map_q;
    ext_d      = ext_q;
    skip_d     = skip_q;
    tail_d     = tail_q;
    rel        = step_i.scan_byte[7];
    key        = step_i.scan_byte[ksd_pkg::KEY_W-1:0];
    drop       = (step_i.scan_byte == ksd_pkg::CODE_NONE) ||
                 (ext_q && ((key == ksd_pkg::KEY_LSHIFT) || (key == ksd_pkg::KEY_RSHIFT)));
    code       = (key == ksd_pkg::KEY_LSHIFT) ? {rel, ksd_pkg::KEY_RSHIFT} : step_i.scan_byte;
    idx        = code[ksd_pkg::KEY_W-1:0];

    if (mode_q) begin
      result_o.resend_seen = (step_i.scan_byte == ksd_pkg::CODE_RESEND);
      result_o.ack_seen    = (step_i.scan_byte == ksd_pkg::CODE_ACK);
    end else if (skip_q != '0) begin
      skip_d = skip_q - 1'b1;
    end else if (step_i.scan_byte == ksd_pkg::CODE_PAUSE) begin
      result_o.pause_seen = 1'b1;
      skip_d              = ksd_pkg::PAUSE_SKIP;
    end else if (step_i.scan_byte == ksd_pkg::CODE_PANIC) begin
      result_o.panic_seen = 1'b1;
    end else if (step_i.scan_byte == ksd_pkg::CODE_EXT) begin
      ext_d = 1'b1;
    end else begin
      if (!drop) begin
        down_map_d[idx]           = !rel;
        result_o.code_valid       = 1'b1;
        result_o.key_code         = code;
        result_o.queue_slot       = tail_ext[ksd_pkg::SLOT_W-1:0];
        result_o.last_scan_update = !rel;
        result_o.key_is_down      = down_map_d[idx];
        // Wrap the tail at the queue depth.
        tail_d = (tail_q == TAIL_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + TAIL_W'(1);
      end
      ext_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      down_map_q <= '0;
      ext_q      <= 1'b0;
      skip_q     <= '0;
      tail_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i.led_command_mode;
      end
      if (step_i.fire) begin
        down_map_q <= down_map_d;
        ext_q      <= ext_d;
        skip_q     <= skip_d;
        tail_q     <= tail_d;
      end
    end
  end

endmodule

// ===== rtl/ksd_out_stage.sv =====
// Result register driving the output channel.
// Depends on ksd_pkg and ksd_stream_if.
module ksd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  ksd_pkg::ksd_result_t result_i,
  output logic                 can_load_o,
  ksd_stream_if.source         key_o
);

  logic                 valid_q;
  ksd_pkg::ksd_result_t data_q;

  // Take a new result when empty or when the held one leaves this cycle.
  assign can_load_o = !valid_q || key_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      data_q <= result_i;
    end
  end

  assign key_o.valid   = valid_q;
  assign key_o.payload = data_q;

endmodule

// ===== rtl/keyboard_scan_code_decoder.sv =====
// Top level of the set-1 keyboard scan code decoder.
// Depends on ksd_pkg, ksd_stream_if, ksd_core, ksd_out_stage and the macros header.
//
// Usage:
//   scan_i carries one raw scan byte per request; key_o returns exactly one
//   result per byte (key code with its queue slot, or pause/panic/ack/resend
//   flags). cfg_i writes led_command_mode; it is always ready and must only
//   be written while no byte is in flight.
// Path: an accepted byte waits in the input register, is decoded into the
//   result register when that register is free, and is offered on key_o from there.
// Throughput: one byte per cycle while key_o takes results; the decode of
//   a byte against the scan state (down map, extended flag, pause skip, queue
//   tail) is one short logic level between the input register and the result
//   register, and the state updates in the same cycle, so the next byte sees it.
// Stall: when key_o is not taken, the result register holds and the input
//   register still takes one more byte; scan_i.ready drops only when both
//   are full.
// Reset: rst_ni (asynchronous, active low) empties both registers, clears
//   the 128-entry down map, extended flag, pause skip count, queue tail and
//   the LED-command mode.
`include "keyboard_scan_code_decoder_macros.svh"

module keyboard_scan_code_decoder #(
  parameter int unsigned QUEUE_DEPTH = ksd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ksd_stream_if.sink   cfg_i,
  ksd_stream_if.sink   scan_i,
  ksd_stream_if.source key_o
);

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 can_load;
  ksd_pkg::ksd_step_t   step;
  ksd_pkg::ksd_result_t result;

  // Config writes are taken at once.
  assign cfg_i.ready = 1'b1;

  // Input register frees up when empty or when its byte moves on.
  assign scan_i.ready = !in_valid_q || can_load;

  // Decode fires when the input holds a byte and the result register can take it.
  assign step.fire      = in_valid_q && can_load;
  assign step.scan_byte = in_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (scan_i.valid && scan_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step.fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Hold the byte until the decode consumes it.
  always_ff @(posedge clk_i) begin
    if (scan_i.valid && scan_i.ready) begin
      in_byte_q <= scan_i.payload.scan_byte;
    end
  end

  ksd_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_i.valid && cfg_i.ready),
    .cfg_data_i(cfg_i.payload),
    .step_i    (step),
    .result_o  (result)
  );

  ksd_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step.fire),
    .result_i  (result),
    .can_load_o(can_load),
    .key_o     (key_o)
  );

  // Backpressure reaches the input only with both registers full and the sink stalled.
  `KSD_ASSERT_IMPLIES(a_stall_only_when_full, !scan_i.ready,
                      in_valid_q && key_o.valid && !key_o.ready)

  // A queued press must leave its key marked down.
  `KSD_ASSERT_IMPLIES(a_press_marks_down, key_o.valid && key_o.payload.last_scan_update,
                      key_o.payload.code_valid && key_o.payload.key_is_down)

  // LED-command replies never carry a key code or a pause/panic report.
  `KSD_ASSERT_IMPLIES(a_led_reply_alone,
                      key_o.valid && (key_o.payload.ack_seen || key_o.payload.resend_seen),
                      !key_o.payload.code_valid && !key_o.payload.pause_seen &&
                      !key_o.payload.panic_seen)

  // A byte consumed by the decode always appears in the result register next cycle.
  `KSD_ASSERT_NEXT(a_fire_fills_output, step.fire, key_o.valid)

endmodule

// ===== bench/keyboard_scan_code_decoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for keyboard_scan_code_decoder: sends scan byte requests
// and LED-command mode writes, and checks every result field by field.
// Depends on ksd_pkg, ksd_stream_if and the decoder RTL.
module keyboard_scan_code_decoder_tb;

  localparam int unsigned IDLE_PCT       = 38;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS   = 1900;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  ksd_stream_if #(.payload_t(ksd_pkg::ksd_cfg_t))    cfg_if ();
  ksd_stream_if #(.payload_t(ksd_pkg::ksd_scan_t))   scan_if ();
  ksd_stream_if #(.payload_t(ksd_pkg::ksd_result_t)) key_if ();

  keyboard_scan_code_decoder dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .scan_i(scan_if),
    .key_o (key_if)
  );

  // Decoder state as the bench tracks it.
  logic                       led_mode;
  logic                       key_down [ksd_pkg::KEY_COUNT];
  logic                       ext_pending;
  logic [ksd_pkg::SKIP_W-1:0] skip_left;
  logic [ksd_pkg::SLOT_W-1:0] tail_slot;

  ksd_pkg::ksd_result_t decoded_q [$];  // results owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned scan_count = 0;
  bit          stall_en   = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned quiet_cycles = 0;
  ksd_pkg::ksd_result_t want_r;

  // Decode one scan byte against the tracked state and advance that state.
  function automatic ksd_pkg::ksd_result_t decode_scan(input logic [7:0] b);
    ksd_pkg::ksd_result_t      r;
    logic [ksd_pkg::KEY_W-1:0] key;
    logic                      rel;
    logic                      drop;
    logic [7:0]                code;
    r   = '0;
    key = b[ksd_pkg::KEY_W-1:0];
    rel = b[7];
    if (led_mode) begin
      // only ack and resend matter while an LED command is outstanding
      if (b == ksd_pkg::CODE_RESEND) r.resend_seen = 1'b1;
      else if (b == ksd_pkg::CODE_ACK) r.ack_seen = 1'b1;
    end else if (skip_left != '0) begin
      skip_left = skip_left - 1'b1;
    end else if (b == ksd_pkg::CODE_PAUSE) begin
      r.pause_seen = 1'b1;
      skip_left    = ksd_pkg::PAUSE_SKIP;
    end else if (b == ksd_pkg::CODE_PANIC) begin
      r.panic_seen = 1'b1;
    end else if (b == ksd_pkg::CODE_EXT) begin
      ext_pending = 1'b1;
    end else begin
      drop = (b == ksd_pkg::CODE_NONE) ||
             (ext_pending && (key == ksd_pkg::KEY_LSHIFT || key == ksd_pkg::KEY_RSHIFT));
      if (!drop) begin
        code = b;
        if (key == ksd_pkg::KEY_LSHIFT) code = {rel, ksd_pkg::KEY_RSHIFT};
        key_down[code[ksd_pkg::KEY_W-1:0]] = !rel;
        r.code_valid       = 1'b1;
        r.key_code         = code;
        r.queue_slot       = tail_slot;
        r.last_scan_update = !rel;
        r.key_is_down      = key_down[code[ksd_pkg::KEY_W-1:0]];
        tail_slot          = tail_slot + 1'b1;  // 32-deep queue wraps with the slot width
      end
      ext_pending = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one scan byte request; called and returns at a falling edge.
  task automatic send_scan(input logic [7:0] b);
    if (stall_en && $urandom_range(99) < IDLE_PCT) begin
      scan_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    scan_if.valid             <= 1'b1;
    scan_if.payload.scan_byte <= b;
    do @(posedge clk); while (!scan_if.ready);
    decoded_q.push_back(decode_scan(b));
    scan_count++;
    @(negedge clk);
  endtask

  // Write LED-command mode once the block has drained.
  task automatic write_led_mode(input logic mode);
    scan_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_if.valid                    <= 1'b1;
    cfg_if.payload.led_command_mode <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    led_mode = mode;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // One well-formed keyboard sequence with random content, or noise.
  task automatic send_sequence();
    int unsigned               pick;
    logic [ksd_pkg::KEY_W-1:0] k;
    pick = $urandom_range(99);
    k    = ksd_pkg::KEY_W'($urandom_range(ksd_pkg::KEY_COUNT - 1));
    if (pick < 40) begin
      send_scan({1'b0, k});
      if ($urandom_range(3) != 0) send_scan({1'b1, k});
    end else if (pick < 55) begin
      send_scan(ksd_pkg::CODE_EXT);
      send_scan(8'($urandom_range(255)));
    end else if (pick < 65) begin
      // fake shift around an extended key
      send_scan(ksd_pkg::CODE_EXT);
      send_scan({1'($urandom_range(1)),
                 ($urandom_range(1) != 0) ? ksd_pkg::KEY_LSHIFT : ksd_pkg::KEY_RSHIFT});
    end else if (pick < 72) begin
      send_scan(ksd_pkg::CODE_PAUSE);
      repeat (5) send_scan(8'($urandom_range(255)));
    end else if (pick < 76) begin
      send_scan(ksd_pkg::CODE_PANIC);
    end else if (pick < 82) begin
      send_scan({1'($urandom_range(1)), ksd_pkg::KEY_LSHIFT});
    end else begin
      send_scan(8'($urandom_range(255)));
    end
  endtask

  // Extremes of the byte, left shift press and release, panic and its release.
  task automatic test_key_extremes();
    send_scan(ksd_pkg::CODE_NONE);
    send_scan(8'h7F);
    send_scan(8'h80);        // release of key zero is still queued
    send_scan(8'hFF);
    send_scan({1'b0, ksd_pkg::KEY_LSHIFT});
    send_scan({1'b1, ksd_pkg::KEY_LSHIFT});
    send_scan(ksd_pkg::CODE_PANIC);
    send_scan(8'hC6);        // panic release decodes as an ordinary key
  endtask

  // Extended prefix: fake shift dropped, panic keeps the prefix pending.
  task automatic test_extended_prefix();
    send_scan(ksd_pkg::CODE_EXT);
    send_scan({1'b0, ksd_pkg::KEY_LSHIFT});
    send_scan(ksd_pkg::CODE_EXT);
    send_scan(ksd_pkg::CODE_PANIC);
    send_scan({1'b1, ksd_pkg::KEY_RSHIFT});
    send_scan(ksd_pkg::CODE_EXT);
    send_scan(8'h1C);
  endtask

  // Pause prefix: the next five bytes are skipped, prefixes included.
  task automatic test_pause_skip();
    send_scan(ksd_pkg::CODE_PAUSE);
    send_scan(ksd_pkg::CODE_PAUSE);
    send_scan(ksd_pkg::CODE_PANIC);
    send_scan(ksd_pkg::CODE_EXT);
    send_scan(ksd_pkg::CODE_NONE);
    send_scan(8'hFF);
    send_scan(8'h1E);
  endtask

  // LED-command mode wins over all else and keeps the extended prefix.
  task automatic test_led_command();
    send_scan(ksd_pkg::CODE_EXT);
    write_led_mode(1'b1);
    send_scan(ksd_pkg::CODE_ACK);
    send_scan(ksd_pkg::CODE_RESEND);
    send_scan(8'h12);
    write_led_mode(1'b0);
    send_scan({1'b0, ksd_pkg::KEY_RSHIFT});
  endtask

  // Stall the result side for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (40) send_sequence();
  endtask

  // Random traffic over alternating modes, one phase without idling.
  task automatic test_random_traffic();
    int unsigned phase_end;
    for (int phase = 0; phase < 8; phase++) begin
      write_led_mode(phase[0]);
      stall_en  = (phase != 4);
      phase_end = scan_count + (phase[0] ? RANDOM_ITEMS / 40 : RANDOM_ITEMS / 4 - 50);
      while (scan_count < phase_end) begin
        if (phase[0]) begin
          case ($urandom_range(2))
            0:       send_scan(ksd_pkg::CODE_ACK);
            1:       send_scan(ksd_pkg::CODE_RESEND);
            default: send_scan(8'($urandom_range(255)));
          endcase
        end else begin
          send_sequence();
        end
      end
    end
    stall_en = 1'b1;
    write_led_mode(1'b0);
  endtask

  // Result side: random stalls, plus the long hold-off on request.
  initial begin
    key_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        key_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      key_if.ready <= !stall_en || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && key_if.valid && key_if.ready) begin
      if (decoded_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want_r = decoded_q.pop_front();
        check_field("code_valid",       want_r.code_valid,       key_if.payload.code_valid);
        check_field("key_code",         want_r.key_code,         key_if.payload.key_code);
        check_field("queue_slot",       want_r.queue_slot,       key_if.payload.queue_slot);
        check_field("last_scan_update", want_r.last_scan_update,
                    key_if.payload.last_scan_update);
        check_field("key_is_down",      want_r.key_is_down,      key_if.payload.key_is_down);
        check_field("pause_seen",       want_r.pause_seen,       key_if.payload.pause_seen);
        check_field("panic_seen",       want_r.panic_seen,       key_if.payload.panic_seen);
        check_field("ack_seen",         want_r.ack_seen,         key_if.payload.ack_seen);
        check_field("resend_seen",      want_r.resend_seen,      key_if.payload.resend_seen);
      end
    end
  end

  // Drop the run if no channel moves for too long.
  always @(posedge clk) begin
    if ((scan_if.valid && scan_if.ready) || (key_if.valid && key_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    scan_if.valid   = 1'b0;
    scan_if.payload = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    led_mode        = 1'b0;
    ext_pending     = 1'b0;
    skip_left       = '0;
    tail_slot       = '0;
    foreach (key_down[i]) key_down[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_key_extremes();
    test_extended_prefix();
    test_pause_skip();
    test_led_command();
    test_backpressure();
    test_random_traffic();

    // drain, then let the pipeline settle before the verdict
    scan_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
